@@ hdl/slx_pkg.sv @@
package slx_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int LINE_BITS_DEF     = 24;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int MAX_TOKENS        = 3;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_BANG_EQ = 6'd12;
  localparam logic [5:0] K_EQ      = 6'd13;
  localparam logic [5:0] K_EQ_EQ   = 6'd14;
  localparam logic [5:0] K_GT      = 6'd15;
  localparam logic [5:0] K_GT_EQ   = 6'd16;
  localparam logic [5:0] K_LT      = 6'd17;
  localparam logic [5:0] K_LT_EQ   = 6'd18;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_AND     = 6'd22;
  localparam logic [5:0] K_CLASS   = 6'd23;
  localparam logic [5:0] K_ELSE    = 6'd24;
  localparam logic [5:0] K_FALSE   = 6'd25;
  localparam logic [5:0] K_FOR     = 6'd26;
  localparam logic [5:0] K_FUN     = 6'd27;
  localparam logic [5:0] K_IF      = 6'd28;
  localparam logic [5:0] K_NIL     = 6'd29;
  localparam logic [5:0] K_OR      = 6'd30;
  localparam logic [5:0] K_PRINT   = 6'd31;
  localparam logic [5:0] K_RETURN  = 6'd32;
  localparam logic [5:0] K_SUPER   = 6'd33;
  localparam logic [5:0] K_THIS    = 6'd34;
  localparam logic [5:0] K_TRUE    = 6'd35;
  localparam logic [5:0] K_VAR     = 6'd36;
  localparam logic [5:0] K_WHILE   = 6'd37;
  localparam logic [5:0] K_ERROR   = 6'd38;
  localparam logic [5:0] K_EOF     = 6'd39;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_IDENT   = 4'd1,
    PH_INT     = 4'd2,
    PH_DOT     = 4'd3,
    PH_FRAC    = 4'd4,
    PH_STRING  = 4'd5,
    PH_OP      = 4'd6,
    PH_COMMENT = 4'd7
  } phase_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t [MAX_TOKENS-1:0] tok;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic two);
    case (c)
      "!": op_kind = two ? K_BANG_EQ : K_BANG;
      "=": op_kind = two ? K_EQ_EQ : K_EQ;
      ">": op_kind = two ? K_GT_EQ : K_GT;
      "<": op_kind = two ? K_LT_EQ : K_LT;
      default: op_kind = K_SLASH;
    endcase
  endfunction

  // w holds the first six characters, first one in the top byte; n is the length
  function automatic logic [5:0] kw_kind(input logic [47:0] w, input logic [2:0] n);
    kw_kind = K_IDENT;
    unique case (n)
      3'd2: begin
        if (w[47:32] == "if") kw_kind = K_IF;
        else if (w[47:32] == "or") kw_kind = K_OR;
      end
      3'd3: begin
        if (w[47:24] == "and") kw_kind = K_AND;
        else if (w[47:24] == "for") kw_kind = K_FOR;
        else if (w[47:24] == "fun") kw_kind = K_FUN;
        else if (w[47:24] == "nil") kw_kind = K_NIL;
        else if (w[47:24] == "var") kw_kind = K_VAR;
      end
      3'd4: begin
        if (w[47:16] == "else") kw_kind = K_ELSE;
        else if (w[47:16] == "this") kw_kind = K_THIS;
        else if (w[47:16] == "true") kw_kind = K_TRUE;
      end
      3'd5: begin
        if (w[47:8] == "class") kw_kind = K_CLASS;
        else if (w[47:8] == "false") kw_kind = K_FALSE;
        else if (w[47:8] == "print") kw_kind = K_PRINT;
        else if (w[47:8] == "super") kw_kind = K_SUPER;
        else if (w[47:8] == "while") kw_kind = K_WHILE;
      end
      3'd6: begin
        if (w == "return") kw_kind = K_RETURN;
      end
      default: kw_kind = K_IDENT;
    endcase
  endfunction

endpackage

@@ hdl/slx_front.sv @@
module slx_front #(
  parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = slx_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = slx_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      char_code,
  output logic            push,
  output slx_pkg::bundle_t bundle
);
  import slx_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic [POSITION_BITS-1:0] pos_r, tstart_r, tstart_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic [7:0]               pfx_r [KEYWORD_CHARS];
  logic [KEYWORD_CHARS-1:0] pfx_we;
  logic [7:0]               pfx_d;
  logic [5:0]               ident_k;
  logic [2:0]               kw_n;
  logic [47:0]              kw_w;

  function automatic logic [31:0] to_start(input logic [POSITION_BITS-1:0] p);
    logic [63:0] t;
    t = 64'(p);
    return t[31:0];
  endfunction

  function automatic logic [15:0] to_len(input logic [LENGTH_BITS-1:0] l);
    logic [31:0] t;
    t = 32'(l);
    return t[15:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] v,
                                                     input logic [1:0] a);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + (LENGTH_BITS+1)'(a);
    return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) kw_w[47-8*i -: 8] = pfx_r[i];
    kw_n = (len_r <= LENGTH_BITS'(6)) ? 3'(len_r) : 3'd7;
    ident_k = kw_kind(kw_w, kw_n);
  end

  always_comb begin
    logic [1:0]               cnt;
    logic                     consumed;
    logic [7:0]               c;
    logic [31:0]              lt;
    logic [POSITION_BITS-1:0] pm1;
    logic [5:0]               pk;
    token_t                   t;

    c = char_code;
    cnt = 2'd0;
    consumed = 1'b0;
    phase_nxt = phase_r;
    pend_nxt = pend_r;
    tstart_nxt = tstart_r;
    line_nxt = line_r;
    len_nxt = len_r;
    pfx_we = '0;
    pfx_d = c;
    bundle = '0;
    pm1 = pos_r - POSITION_BITS'(1);
    pk = K_ERROR;
    lt = 32'(line_r);
    t = '0;

    if (c != 8'd0) begin
      unique case (phase_r)
        PH_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++)
              if (len_r == LENGTH_BITS'(i)) pfx_we[i] = 1'b1;
            len_nxt = sat_add(len_r, 2'd1);
            consumed = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit(c)) begin
            len_nxt = sat_add(len_r, 2'd1);
            consumed = 1'b1;
          end else if (c == ".") begin
            phase_nxt = PH_DOT;
            consumed = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_digit(c)) begin
            len_nxt = sat_add(len_r, 2'd2);
            phase_nxt = PH_FRAC;
            consumed = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit(c)) begin
            len_nxt = sat_add(len_r, 2'd1);
            consumed = 1'b1;
          end
        end
        PH_STRING: begin
          len_nxt = sat_add(len_r, 2'd1);
          if (c == "\"") begin
            lt = 32'(line_r);
            bundle.tok[cnt] = '{K_STRING, ERR_NONE, to_start(tstart_r), to_len(len_nxt),
                                lt[23:0]};
            cnt = cnt + 2'd1;
            phase_nxt = PH_IDLE;
          end else if (c == "\n" && line_r < LINE_MAX) begin
            line_nxt = line_r + LINE_BITS'(1);
          end
          consumed = 1'b1;
        end
        PH_OP: begin
          if (pend_r == "/" && c == "/") begin
            phase_nxt = PH_COMMENT;
            consumed = 1'b1;
          end else if (pend_r != "/" && c == "=") begin
            lt = 32'(line_r);
            bundle.tok[cnt] = '{op_kind(pend_r, 1'b1), ERR_NONE, to_start(tstart_r), 16'd2,
                                lt[23:0]};
            cnt = cnt + 2'd1;
            phase_nxt = PH_IDLE;
            consumed = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (c != "\n") consumed = 1'b1;
        end
        default: ;
      endcase
    end

    if (!consumed) begin
      lt = 32'(line_r);
      // close whatever token is still open
      unique case (phase_r)
        PH_IDENT: begin
          bundle.tok[cnt] = '{ident_k, ERR_NONE, to_start(tstart_r), to_len(len_r), lt[23:0]};
          cnt = cnt + 2'd1;
        end
        PH_INT, PH_FRAC: begin
          bundle.tok[cnt] = '{K_NUMBER, ERR_NONE, to_start(tstart_r), to_len(len_r),
                              lt[23:0]};
          cnt = cnt + 2'd1;
        end
        PH_DOT: begin
          bundle.tok[cnt] = '{K_NUMBER, ERR_NONE, to_start(tstart_r), to_len(len_r),
                              lt[23:0]};
          cnt = cnt + 2'd1;
          bundle.tok[cnt] = '{K_DOT, ERR_NONE, to_start(pm1), 16'd1, lt[23:0]};
          cnt = cnt + 2'd1;
        end
        PH_OP: begin
          bundle.tok[cnt] = '{op_kind(pend_r, 1'b0), ERR_NONE, to_start(tstart_r), 16'd1,
                              lt[23:0]};
          cnt = cnt + 2'd1;
        end
        PH_STRING: begin
          bundle.tok[cnt] = '{K_ERROR, ERR_STRING, to_start(tstart_r), to_len(len_r),
                              lt[23:0]};
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      phase_nxt = PH_IDLE;

      if (c == 8'd0) begin
        bundle.tok[cnt] = '{K_EOF, ERR_NONE, to_start(pos_r), 16'd0, lt[23:0]};
        cnt = cnt + 2'd1;
      end else if (c == " " || c == 8'h0D || c == "\t") begin
      end else if (c == "\n") begin
        if (line_r < LINE_MAX) line_nxt = line_r + LINE_BITS'(1);
      end else if (is_alpha(c)) begin
        phase_nxt = PH_IDENT;
        tstart_nxt = pos_r;
        len_nxt = LENGTH_BITS'(1);
        pfx_we[0] = 1'b1;
      end else if (is_digit(c)) begin
        phase_nxt = PH_INT;
        tstart_nxt = pos_r;
        len_nxt = LENGTH_BITS'(1);
      end else if (c == "\"") begin
        phase_nxt = PH_STRING;
        tstart_nxt = pos_r;
        len_nxt = LENGTH_BITS'(1);
      end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
        phase_nxt = PH_OP;
        tstart_nxt = pos_r;
        len_nxt = LENGTH_BITS'(1);
        pend_nxt = c;
      end else begin
        case (c)
          "(": pk = K_LPAREN;
          ")": pk = K_RPAREN;
          "{": pk = K_LBRACE;
          "}": pk = K_RBRACE;
          ",": pk = K_COMMA;
          ".": pk = K_DOT;
          "-": pk = K_MINUS;
          "+": pk = K_PLUS;
          ";": pk = K_SEMI;
          "*": pk = K_STAR;
          default: pk = K_ERROR;
        endcase
        t = '{pk, (pk == K_ERROR) ? ERR_CHAR : ERR_NONE, to_start(pos_r), 16'd1, lt[23:0]};
        bundle.tok[cnt] = t;
        cnt = cnt + 2'd1;
      end
    end
    bundle.count = cnt;
  end

  assign push = take && (bundle.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r <= 8'd0;
      pos_r <= '0;
      tstart_r <= '0;
      line_r <= LINE_BITS'(1);
      len_r <= '0;
    end else if (take) begin
      if (char_code == 8'd0) begin
        phase_r <= PH_IDLE;
        pend_r <= 8'd0;
        pos_r <= '0;
        tstart_r <= '0;
        line_r <= LINE_BITS'(1);
        len_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        pend_r <= pend_nxt;
        pos_r <= pos_r + POSITION_BITS'(1);
        tstart_r <= tstart_nxt;
        line_r <= line_nxt;
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && char_code != 8'd0) begin
      for (int i = 0; i < KEYWORD_CHARS; i++)
        if (pfx_we[i]) pfx_r[i] <= pfx_d;
    end
  end

endmodule

@@ hdl/slx_queue.sv @@
module slx_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  slx_pkg::bundle_t wdata,
  input  logic             rd,
  output slx_pkg::bundle_t rdata,
  output logic             full,
  output logic             empty
);
  import slx_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  bundle_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PW'(QUEUE_DEPTH-1)) ? '0 : wp_r + PW'(1);
      if (rd) rp_r <= (rp_r == PW'(QUEUE_DEPTH-1)) ? '0 : rp_r + PW'(1);
      if (wr && !rd) cnt_r <= cnt_r + (PW+1)'(1);
      else if (rd && !wr) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

endmodule

@@ hdl/slx_back.sv @@
module slx_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  slx_pkg::bundle_t q_data,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output slx_pkg::token_t  tok,
  output logic             last
);
  import slx_pkg::*;

  bundle_t    cur_r;
  logic       have_r;
  logic [1:0] idx_r;
  logic       done;

  assign last  = (idx_r == cur_r.count - 2'd1);
  assign done  = pop && have_r && last;
  assign q_rd  = !q_empty && (!have_r || done);
  assign empty = !have_r;

  always_comb begin
    case (idx_r)
      2'd0: tok = cur_r.tok[0];
      2'd1: tok = cur_r.tok[1];
      default: tok = cur_r.tok[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (q_rd) begin
      have_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (done) begin
      have_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (pop && have_r) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur_r <= q_data;
  end

endmodule

@@ hdl/script_lexer.sv @@
// Streaming source scanner: one byte is taken per cycle whenever full is low, and
// tokens come out in order, one per cycle when popped. A byte can produce up to three
// tokens; the last one it produces has out_last_of_run set. When the output stage is idle
// the first token of a byte is written to the queue, then loaded into the output stage.
// Sustained input rate is one byte per cycle as long as tokens are popped at least as fast
// as they are made; a byte that makes several tokens holds the output stage for that many
// pops, and a two-entry queue between the scanning front end and the token output stage
// absorbs short bursts. A zero byte flushes the open token, emits end of source and
// returns the scanner to its reset state.
module script_lexer #(
  parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = slx_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = slx_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_token_kind,
  output logic [1:0]  out_error_kind,
  output logic [31:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [23:0] out_token_line,
  output logic        out_last_of_run
);
  import slx_pkg::*;

  logic    take, q_wr, q_rd, q_full, q_empty;
  bundle_t f_bundle, q_data;
  token_t  tok;

  assign full = q_full;
  assign take = push && !q_full;

  slx_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .char_code(in_char_code),
    .push     (q_wr),
    .bundle   (f_bundle)
  );

  slx_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(f_bundle),
    .rd   (q_rd),
    .rdata(q_data),
    .full (q_full),
    .empty(q_empty)
  );

  slx_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_data (q_data),
    .q_rd   (q_rd),
    .pop    (pop),
    .empty  (empty),
    .tok    (tok),
    .last   (out_last_of_run)
  );

  assign out_token_kind   = tok.kind;
  assign out_error_kind   = tok.err;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.len;
  assign out_token_line   = tok.line;

endmodule

@@ hdl/slx_checker.sv @@
module slx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [5:0]  out_token_kind,
  input logic [1:0]  out_error_kind,
  input logic [23:0] out_token_line,
  input logic        out_last_of_run
);
  import slx_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_token_kind)))
    else $error("stalled token changed");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_kind == K_EOF) |-> out_last_of_run)
    else $error("end of source not last of run");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error_kind != ERR_NONE) |-> out_token_kind == K_ERROR)
    else $error("error code on non-error token");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_token_line != 24'd0)
    else $error("line number zero");

endmodule

bind script_lexer slx_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .empty          (empty),
  .pop            (pop),
  .out_token_kind (out_token_kind),
  .out_error_kind (out_error_kind),
  .out_token_line (out_token_line),
  .out_last_of_run(out_last_of_run)
);

@@ tb/sv/tb_script_lexer.sv @@
module tb_script_lexer;
  timeunit 1ns;
  timeprecision 1ps;
  import slx_pkg::*;

  localparam int LEN_SAT  = 65535;
  localparam int LINE_SAT = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic        last;
  } tok_s;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char_code;
  logic        empty;
  logic        pop;
  logic [5:0]  out_token_kind;
  logic [1:0]  out_error_kind;
  logic [31:0] out_token_start;
  logic [15:0] out_token_length;
  logic [23:0] out_token_line;
  logic        out_last_of_run;

  script_lexer dut (.*);

  // scanner shadow state
  phase_t      sc_phase;
  logic [7:0]  sc_op_char;
  logic [31:0] sc_pos;
  logic [23:0] sc_line;
  logic [31:0] sc_tok_start;
  logic [15:0] sc_len;
  logic [7:0]  sc_word [6];

  logic [7:0] byte_q [$];
  tok_s       token_q [$];
  tok_s       step_toks [$];
  int         mismatches;
  longint     cycles;
  bit         quiet;
  bit         src_idle_on;
  bit         sink_idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] len_add(logic [15:0] v, int add);
    return (int'(v) + add > LEN_SAT) ? 16'(LEN_SAT) : 16'(int'(v) + add);
  endfunction

  function automatic void add_token(logic [5:0] k, logic [1:0] e, logic [31:0] s,
                                    logic [15:0] l);
    tok_s t;
    if (step_toks.size() >= MAX_TOKENS) return;
    t.kind = k; t.err = e; t.start = s; t.len = l; t.line = sc_line; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic logic [5:0] word_kind();
    string w;
    w = "";
    if (sc_len > 6) return K_IDENT;
    for (int i = 0; i < sc_len; i++) w = {w, string'(sc_word[i])};
    case (w)
      "and": return K_AND;        "class": return K_CLASS;
      "else": return K_ELSE;      "false": return K_FALSE;
      "for": return K_FOR;        "fun": return K_FUN;
      "if": return K_IF;          "nil": return K_NIL;
      "or": return K_OR;          "print": return K_PRINT;
      "return": return K_RETURN;  "super": return K_SUPER;
      "this": return K_THIS;      "true": return K_TRUE;
      "var": return K_VAR;        "while": return K_WHILE;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic logic [5:0] oper_kind(logic [7:0] c, bit two);
    case (c)
      "!": return two ? K_BANG_EQ : K_BANG;
      "=": return two ? K_EQ_EQ : K_EQ;
      ">": return two ? K_GT_EQ : K_GT;
      "<": return two ? K_LT_EQ : K_LT;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic void scan_reset();
    sc_phase = PH_IDLE; sc_op_char = '0; sc_pos = '0; sc_line = 24'd1;
    sc_tok_start = '0; sc_len = '0;
    for (int i = 0; i < 6; i++) sc_word[i] = '0;
  endfunction

  function automatic void close_token(logic [31:0] pos);
    case (sc_phase)
      PH_IDENT: add_token(word_kind(), ERR_NONE, sc_tok_start, sc_len);
      PH_INT, PH_FRAC: add_token(K_NUMBER, ERR_NONE, sc_tok_start, sc_len);
      PH_DOT: begin
        add_token(K_NUMBER, ERR_NONE, sc_tok_start, sc_len);
        add_token(K_DOT, ERR_NONE, pos - 1, 16'd1);
      end
      PH_OP: add_token(oper_kind(sc_op_char, 1'b0), ERR_NONE, sc_tok_start, 16'd1);
      PH_STRING: add_token(K_ERROR, ERR_STRING, sc_tok_start, sc_len);
      default: ;
    endcase
    sc_phase = PH_IDLE;
  endfunction

  function automatic void open_token(phase_t ph, logic [31:0] pos);
    sc_phase = ph; sc_tok_start = pos; sc_len = 16'd1;
  endfunction

  function automatic void idle_char(logic [7:0] c, logic [31:0] pos);
    logic [5:0] k;
    sc_phase = PH_IDLE;
    if (c == " " || c == 8'h0D || c == 8'h09) return;
    if (c == 8'h0A) begin
      if (sc_line < LINE_SAT) sc_line++;
      return;
    end
    if (alpha_c(c)) begin
      open_token(PH_IDENT, pos);
      sc_word[0] = c;
      return;
    end
    if (digit_c(c)) begin
      open_token(PH_INT, pos);
      return;
    end
    if (c == "\"") begin
      open_token(PH_STRING, pos);
      return;
    end
    if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
      open_token(PH_OP, pos);
      sc_op_char = c;
      return;
    end
    case (c)
      "(": k = K_LPAREN;  ")": k = K_RPAREN;
      "{": k = K_LBRACE;  "}": k = K_RBRACE;
      ",": k = K_COMMA;   ".": k = K_DOT;
      "-": k = K_MINUS;   "+": k = K_PLUS;
      ";": k = K_SEMI;    "*": k = K_STAR;
      default: begin
        add_token(K_ERROR, ERR_CHAR, pos, 16'd1);
        return;
      end
    endcase
    add_token(k, ERR_NONE, pos, 16'd1);
  endfunction

  // predicts the tokens caused by one source byte and queues them
  function automatic void scan_byte(logic [7:0] c);
    logic [31:0] pos;
    bit taken;
    pos = sc_pos;
    taken = 1'b0;
    step_toks.delete();
    if (c == 8'h00) begin
      close_token(pos);
      add_token(K_EOF, ERR_NONE, pos, 16'd0);
      scan_reset();
    end else begin
      case (sc_phase)
        PH_IDENT: if (alpha_c(c) || digit_c(c)) begin
          if (sc_len < 6) sc_word[sc_len] = c;
          sc_len = len_add(sc_len, 1);
          taken = 1'b1;
        end
        PH_INT: if (digit_c(c)) begin
          sc_len = len_add(sc_len, 1);
          taken = 1'b1;
        end else if (c == ".") begin
          sc_phase = PH_DOT;
          taken = 1'b1;
        end
        PH_DOT: if (digit_c(c)) begin
          sc_len = len_add(sc_len, 2);
          sc_phase = PH_FRAC;
          taken = 1'b1;
        end
        PH_FRAC: if (digit_c(c)) begin
          sc_len = len_add(sc_len, 1);
          taken = 1'b1;
        end
        PH_STRING: begin
          sc_len = len_add(sc_len, 1);
          if (c == "\"") begin
            add_token(K_STRING, ERR_NONE, sc_tok_start, sc_len);
            sc_phase = PH_IDLE;
          end else if (c == 8'h0A && sc_line < LINE_SAT) begin
            sc_line++;
          end
          taken = 1'b1;
        end
        PH_OP: if (sc_op_char == "/" && c == "/") begin
          sc_phase = PH_COMMENT;
          taken = 1'b1;
        end else if (sc_op_char != "/" && c == "=") begin
          add_token(oper_kind(sc_op_char, 1'b1), ERR_NONE, sc_tok_start, 16'd2);
          sc_phase = PH_IDLE;
          taken = 1'b1;
        end
        PH_COMMENT: if (c != 8'h0A) taken = 1'b1;
          else sc_phase = PH_IDLE;
        default: sc_phase = PH_IDLE;
      endcase
      if (!taken) begin
        close_token(pos);
        idle_char(c, pos);
      end
      sc_pos = pos + 1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  function automatic string pick_word();
    string w [22] = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                      "print", "return", "super", "this", "true", "var", "while",
                      "ff", "iff", "returns", "classy", "x_1", "Ab9"};
    return w[$urandom_range(0, 21)];
  endfunction

  function automatic string pick_piece();
    string s;
    case ($urandom_range(0, 11))
      0, 1, 2: s = pick_word();
      3: s = $sformatf("%0d", $urandom_range(0, 99999));
      4: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
      5: s = "\"ab c\nd\"";
      6: s = "// note here\n";
      7: begin
        string ops [8] = '{"!=", "==", ">=", "<=", "!", "=", ">", "<"};
        s = ops[$urandom_range(0, 7)];
      end
      8: begin
        string pn [11] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "/"};
        s = pn[$urandom_range(0, 10)];
      end
      9: s = "\n";
      10: s = "5.x";
      default: s = {string'(8'($urandom_range(1, 255)))};
    endcase
    return s;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (byte_q.size() > 0 && !quiet && !(src_idle_on && $urandom_range(0, 99) < 17)) begin
        push <= 1'b1;
        in_char_code <= byte_q[0];
      end else begin
        push <= 1'b0;
      end
      pop <= !(sink_idle_on && $urandom_range(0, 99) < 17);
    end
  end

  // monitor
  always @(posedge clk) begin
    tok_s exp_t;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n) begin
      if (push && !full) begin
        scan_byte(in_char_code);
        void'(byte_q.pop_front());
      end
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token kind %0d", out_token_kind);
        end else begin
          exp_t = token_q.pop_front();
          if (exp_t.kind !== out_token_kind || exp_t.err !== out_error_kind ||
              exp_t.start !== out_token_start || exp_t.len !== out_token_length ||
              exp_t.line !== out_token_line || exp_t.last !== out_last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token mismatch: exp k%0d e%0d s%0d l%0d ln%0d last%0b",
                       exp_t.kind, exp_t.err, exp_t.start, exp_t.len, exp_t.line,
                       exp_t.last);
              $display("                got k%0d e%0d s%0d l%0d ln%0d last%0b",
                       out_token_kind, out_error_kind, out_token_start, out_token_length,
                       out_token_line, out_last_of_run);
            end
          end
        end
      end
    end
  end

  initial begin
    string s;
    cycles = 0;
    mismatches = 0;
    quiet = 1'b0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_char_code = '0;
    scan_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: words, keywords, near misses, numbers, ops, strings, errors
    put_text("if ff or and fun x_Z9 returns return(){},.-+;*/ // c\n");
    put_text("12.5 7.a 3. !a!=b=c==d>e>=f<g<=h \"s\nt\" \x80\xff@");
    put_text("abcdefghij 0");
    byte_q.push_back(8'h00);
    put_text("\"open");
    byte_q.push_back(8'h00);
    put_text("42");
    byte_q.push_back(8'h00);
    while (byte_q.size() > 0 || token_q.size() > 0) @(posedge clk);

    // random text with idles on both sides
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    for (int n = 0; n < 240; ) begin
      if ($urandom_range(0, 29) == 0) begin
        byte_q.push_back(8'h00);
        n++;
      end else begin
        s = pick_piece();
        put_text(s);
        n += s.len();
        if ($urandom_range(0, 1)) begin
          put_text(" ");
          n++;
        end
      end
    end
    byte_q.push_back(8'h00);

    // long stretch with no idling in the middle of the random text
    while (byte_q.size() > 160) @(posedge clk);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    while (byte_q.size() > 60) @(posedge clk);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;

    while (byte_q.size() > 0 || token_q.size() > 0) begin
      @(posedge clk);
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
